[hw/rtl/iva_pkg.sv]
// ----------------------------------------------------------------------------
// iva_pkg : shared types and constants for the interrupt vector allocator
// Vector range, slot geometry, opcodes and the structs between the modules.
// ----------------------------------------------------------------------------
package iva_pkg;

  localparam int NUM_VECTORS = 224;
  localparam int VECTOR_BASE = 32;

  // Slots that actually map to a vector number of at most 255.
  localparam int SLOT_COUNT = (VECTOR_BASE + NUM_VECTORS > 256) ?
                              (256 - VECTOR_BASE) : NUM_VECTORS;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Free search runs over groups of eight slots.
  localparam int GROUP_SIZE  = 8;
  localparam int GIDX_W      = 3;
  localparam int GROUP_COUNT = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  localparam int DATA_W    = 64;
  localparam int PAYLOAD_W = 2 * DATA_W;

  localparam logic [7:0] FIXED_SKIP_VECTOR = 8'h80;
  localparam logic [7:0] RESERVED_RESET    = 8'd254;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_ALLOC_SPEC = 2'd2,
    OP_LOOKUP     = 2'd3
  } op_e;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic  en;
    slot_t slot;
    logic  occupied;
  } occ_wr_t;

  typedef struct packed {
    logic  found;
    slot_t slot;
  } search_t;

  // True when v names a slot of the table.
  function automatic logic slot_valid(input logic [7:0] v);
    logic [8:0] d;
    d = {1'b0, v} - 9'(VECTOR_BASE);
    return ({1'b0, v} >= 9'(VECTOR_BASE)) && (d < 9'(SLOT_COUNT));
  endfunction

  function automatic slot_t slot_index(input logic [7:0] v);
    logic [8:0] d;
    d = {1'b0, v} - 9'(VECTOR_BASE);
    return d[SLOT_W-1:0];
  endfunction

  function automatic logic [7:0] vector_of(input slot_t s);
    logic [8:0] v;
    v = 9'(VECTOR_BASE) + 9'(s);
    return v[7:0];
  endfunction

endpackage

[hw/rtl/iva_payload_ram.sv]
// ----------------------------------------------------------------------------
// iva_payload_ram : single-port payload memory
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module iva_payload_ram #(
  parameter int DEPTH  = 224,
  parameter int WIDTH  = 128,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

[hw/rtl/iva_occ_map.sv]
// ----------------------------------------------------------------------------
// iva_occ_map : occupancy bitmap and first-free search
// Bitmap in flops; per-group search registered, group pick in the next cycle.
// ----------------------------------------------------------------------------
module iva_occ_map (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iva_pkg::occ_wr_t wr_i,
  input  logic [7:0]       reserved_vector_i,
  input  iva_pkg::slot_t   rd_slot_i,
  output logic             rd_occupied_o,
  output iva_pkg::search_t search_o
);

  localparam int PAD_SLOTS = iva_pkg::GROUP_COUNT * iva_pkg::GROUP_SIZE;

  logic [iva_pkg::SLOT_COUNT-1:0] occ_q;
  logic [PAD_SLOTS-1:0]           avail;

  logic [iva_pkg::GROUP_COUNT-1:0] grp_any_d, grp_any_q;
  logic [iva_pkg::GIDX_W-1:0]      grp_idx_d [iva_pkg::GROUP_COUNT];
  logic [iva_pkg::GIDX_W-1:0]      grp_idx_q [iva_pkg::GROUP_COUNT];

  logic                            fix_ok, rv_ok;
  iva_pkg::slot_t                  fix_slot, rv_slot;
  logic [iva_pkg::GRP_W-1:0]       pick_grp;
  logic [iva_pkg::GIDX_W-1:0]      pick_idx;
  logic [iva_pkg::GRP_W+iva_pkg::GIDX_W-1:0] pick_cat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (wr_i.en) begin
      occ_q[wr_i.slot] <= wr_i.occupied;
    end
  end

  assign rd_occupied_o = occ_q[rd_slot_i];

  // Free and not refused.
  always_comb begin
    fix_ok   = iva_pkg::slot_valid(iva_pkg::FIXED_SKIP_VECTOR);
    fix_slot = iva_pkg::slot_index(iva_pkg::FIXED_SKIP_VECTOR);
    rv_ok    = iva_pkg::slot_valid(reserved_vector_i);
    rv_slot  = iva_pkg::slot_index(reserved_vector_i);
    avail    = '0;
    for (int s = 0; s < iva_pkg::SLOT_COUNT; s++) begin
      avail[s] = !occ_q[s]
               && !(fix_ok && (fix_slot == iva_pkg::slot_t'(s)))
               && !(rv_ok  && (rv_slot  == iva_pkg::slot_t'(s)));
    end
  end

  // Per group: any free, lowest free index.
  always_comb begin
    for (int g = 0; g < iva_pkg::GROUP_COUNT; g++) begin
      grp_any_d[g] = |avail[g*iva_pkg::GROUP_SIZE +: iva_pkg::GROUP_SIZE];
      grp_idx_d[g] = '0;
      for (int i = iva_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
        if (avail[g*iva_pkg::GROUP_SIZE + i]) begin
          grp_idx_d[g] = iva_pkg::GIDX_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    grp_idx_q <= grp_idx_d;
  end

  // Lowest group with a free slot.
  always_comb begin
    pick_grp = '0;
    for (int g = iva_pkg::GROUP_COUNT - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        pick_grp = iva_pkg::GRP_W'(g);
      end
    end
    pick_idx       = grp_idx_q[pick_grp];
    pick_cat       = {pick_grp, pick_idx};
    search_o.found = |grp_any_q;
    search_o.slot  = iva_pkg::SLOT_W'(pick_cat);
  end

endmodule

[hw/rtl/interrupt_vector_allocator_unit.sv]
// ----------------------------------------------------------------------------
// interrupt_vector_allocator_unit : interrupt vector table allocator
// Allocates, frees, overwrites and looks up handler/context pairs by vector.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis_*): one word per operation, opcode in tuser.
//   Output stream (m_axis_*): exactly one result word per input word, in order.
//   cfg_we_i / cfg_wdata_i write the reserved vector; write only while idle.
// Sequence
//   Each word passes through four steps: accept, free search (bitmap group
//   summary is registered), execute (payload memory read or write, bitmap
//   update), and response (memory read data lands in the output register).
//   The next word is accepted only after the response loads, so a new word
//   is not taken before the last one is through. The single payload memory
//   port and the two-stage free search set this pace.
// Reset
//   All vectors free, reserved vector 254, output stream empty. Payload
//   memory is not cleared; its data is only used for occupied vectors.
// Stall
//   The output register holds a result until taken; a new word is still
//   accepted and processed, and waits in the response step if the previous
//   result has not yet been taken.
// ----------------------------------------------------------------------------
module interrupt_vector_allocator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,       // reserved_vector
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,      // vector[7:0], handler_address[71:8],
                                          // context_word[135:72]
  input  logic [1:0]   s_axis_tuser,      // opcode
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata       // ok[0], granted_vector[8:1],
                                          // handler_out[72:9],
                                          // context_out[136:73], zero pad
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC,
    ST_RESP
  } state_e;

  state_e state_q;

  logic [7:0] rv_q;

  // captured word
  iva_pkg::op_e                op_q;
  logic [7:0]                  vec_q;
  logic [iva_pkg::DATA_W-1:0]  hdl_q, ctx_q;

  // execute results
  logic       res_ok_q, res_hit_q;
  logic [7:0] res_granted_q;
  logic       ex_ok, ex_hit;
  logic [7:0] ex_granted;

  logic                         m_valid_q;
  logic [143:0]                 m_data_q;

  iva_pkg::occ_wr_t             occ_wr;
  iva_pkg::search_t             search;
  iva_pkg::slot_t               vslot;
  logic                         vec_ok, refused, rd_occ;

  logic                         ram_we, ram_re;
  iva_pkg::slot_t               ram_addr;
  logic [iva_pkg::PAYLOAD_W-1:0] ram_wdata, ram_rdata;

  logic s_accept, resp_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign resp_load     = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // reserved vector register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= iva_pkg::RESERVED_RESET;
    end else if (cfg_we_i) begin
      rv_q <= cfg_wdata_i;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q  <= iva_pkg::op_e'(s_axis_tuser);
      vec_q <= s_axis_tdata[7:0];
      hdl_q <= s_axis_tdata[71:8];
      ctx_q <= s_axis_tdata[135:72];
    end
  end

  // execute step decode
  always_comb begin
    vec_ok     = iva_pkg::slot_valid(vec_q);
    vslot      = iva_pkg::slot_index(vec_q);
    refused    = (vec_q == iva_pkg::FIXED_SKIP_VECTOR) || (vec_q == rv_q);
    ex_ok      = 1'b0;
    ex_hit     = 1'b0;
    ex_granted = vec_q;
    occ_wr     = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = vslot;
    ram_wdata  = {ctx_q, hdl_q};
    unique case (op_q)
      iva_pkg::OP_ALLOC: begin
        ex_ok      = search.found;
        ex_granted = search.found ? iva_pkg::vector_of(search.slot) : 8'd0;
        ram_addr   = search.slot;
        ram_we     = search.found;
      end
      iva_pkg::OP_FREE: begin
        ex_ok     = vec_ok;
        ram_we    = vec_ok;
        ram_wdata = '0;
      end
      iva_pkg::OP_ALLOC_SPEC: begin
        ex_ok  = vec_ok && !refused;
        ram_we = ex_ok;
      end
      iva_pkg::OP_LOOKUP: begin
        ex_ok  = vec_ok;
        ex_hit = vec_ok && rd_occ;
        ram_re = vec_ok;
      end
      default: ;
    endcase
    if (state_q != ST_EXEC) begin
      ram_we = 1'b0;
      ram_re = 1'b0;
    end
    occ_wr.en       = ram_we;
    occ_wr.slot     = ram_addr;
    occ_wr.occupied = (op_q != iva_pkg::OP_FREE) && (hdl_q != '0);
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      res_ok_q      <= 1'b0;
      res_hit_q     <= 1'b0;
      res_granted_q <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          res_ok_q      <= ex_ok;
          res_hit_q     <= ex_hit;
          res_granted_q <= ex_granted;
          state_q       <= ST_RESP;
        end
        ST_RESP: begin
          if (resp_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // memory word is {context, handler}, matching the output field order
      if (resp_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {7'd0,
                      (res_hit_q ? ram_rdata : iva_pkg::PAYLOAD_W'(0)),
                      res_granted_q, res_ok_q};
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  iva_occ_map u_occ_map (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .wr_i              (occ_wr),
    .reserved_vector_i (rv_q),
    .rd_slot_i         (vslot),
    .rd_occupied_o     (rd_occ),
    .search_o          (search)
  );

  iva_payload_ram #(
    .DEPTH  (iva_pkg::SLOT_COUNT),
    .WIDTH  (iva_pkg::PAYLOAD_W),
    .ADDR_W (iva_pkg::SLOT_W)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Assertions

  a_accept_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_SEARCH))
    else $error("accepted word did not start the free search");

  a_alloc_skips_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && op_q == iva_pkg::OP_ALLOC && search.found) |->
      (iva_pkg::vector_of(search.slot) != iva_pkg::FIXED_SKIP_VECTOR &&
       iva_pkg::vector_of(search.slot) != rv_q))
    else $error("allocation picked a refused vector");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_RESP))
    else $error("result appeared outside the response step");

  a_hit_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && res_hit_q) |-> res_ok_q)
    else $error("lookup hit without success");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench : self-checking bench for interrupt_vector_allocator_unit
// Drives allocate, free, allocate-specific and lookup words into the input
// stream and runs a cycle-free model of the vector table beside the block.
// Each output word is checked field by field against the oldest prediction.
// Both stream sides idle in random bursts when enabled. The reserved
// vector is rewritten between phases, only while no result is outstanding.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_CAP     = 40;

  // one input word, split into its fields
  typedef struct packed {
    iva_pkg::op_e opcode;
    logic [7:0]   vector;
    logic [63:0]  handler;
    logic [63:0]  ctx;
  } vec_request_t;

  // laid out exactly as m_axis_tdata[136:0]
  typedef struct packed {
    logic [63:0] ctx;
    logic [63:0] handler;
    logic [7:0]  granted;
    logic        ok;
  } vec_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [7:0]   cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata  = '0;   // vector, handler_address, context_word
  logic [1:0]   s_axis_tuser  = '0;   // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;         // ok, granted_vector, handler_out,
                                      // context_out, zero pad

  // model of the vector table
  bit   [iva_pkg::SLOT_COUNT-1:0] slot_busy;
  logic [63:0]           handler_tbl [iva_pkg::SLOT_COUNT];
  logic [63:0]           context_tbl [iva_pkg::SLOT_COUNT];
  logic [7:0]            reserved_q = iva_pkg::RESERVED_RESET;

  vec_result_t expected_results [$];
  int          mismatch_count     = 0;
  int          quiet_cycles       = 0;
  int          stall_left         = 0;
  bit          sender_gaps_on     = 1'b1;
  bit          receiver_stalls_on = 1'b1;

  always #5 clk_i = ~clk_i;

  interrupt_vector_allocator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // 0x80 and the programmed reserved vector are never handed out
  function automatic bit is_refused(input logic [7:0] v);
    return (v == iva_pkg::FIXED_SKIP_VECTOR) || (v == reserved_q);
  endfunction

  // occupancy follows the handler: a zero handler leaves the slot free
  function automatic void fill_slot(input int idx, input logic [63:0] h,
                                    input logic [63:0] c);
    handler_tbl[idx] = h;
    context_tbl[idx] = c;
    slot_busy[idx]   = (h != '0);
  endfunction

  // Applies one accepted word to the table, returns the word the block owes.
  function automatic vec_result_t apply_vector_op(input vec_request_t rq);
    vec_result_t r;
    int          idx;
    bit          in_table;
    bit          taken;
    r         = '0;
    r.granted = rq.vector;
    idx       = int'(rq.vector) - iva_pkg::VECTOR_BASE;
    in_table  = (idx >= 0) && (idx < iva_pkg::SLOT_COUNT);
    taken     = 1'b0;
    case (rq.opcode)
      iva_pkg::OP_ALLOC: begin
        // lowest free, non-refused slot wins; vector field is ignored
        r.granted = '0;
        for (int s = 0; s < iva_pkg::SLOT_COUNT; s++) begin
          if (!taken && !slot_busy[s] &&
              !is_refused(8'(iva_pkg::VECTOR_BASE + s))) begin
            fill_slot(s, rq.handler, rq.ctx);
            r.ok      = 1'b1;
            r.granted = 8'(iva_pkg::VECTOR_BASE + s);
            taken     = 1'b1;
          end
        end
      end
      iva_pkg::OP_FREE: begin
        if (in_table) begin
          fill_slot(idx, '0, '0);
          r.ok = 1'b1;
        end
      end
      iva_pkg::OP_ALLOC_SPEC: begin
        if (in_table && !is_refused(rq.vector)) begin
          fill_slot(idx, rq.handler, rq.ctx);
          r.ok = 1'b1;
        end
      end
      iva_pkg::OP_LOOKUP: begin
        if (in_table) begin
          r.ok = 1'b1;
          if (slot_busy[idx]) begin
            r.handler = handler_tbl[idx];
            r.ctx     = context_tbl[idx];
          end
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side: every task is entered and left at a rising edge
  // --------------------------------------------------------------------------
  // Sends one word; tvalid stays high on return so back-to-back words need
  // no second assignment in the same step.
  task automatic send_word(input vec_request_t rq);
    if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.opcode;
    s_axis_tdata  <= {rq.ctx, rq.handler, rq.vector};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(apply_vector_op(rq));
  endtask

  task automatic send_op(input iva_pkg::op_e op, input logic [7:0] v,
                         input logic [63:0] h, input logic [63:0] c);
    vec_request_t rq;
    rq.opcode  = op;
    rq.vector  = v;
    rq.handler = h;
    rq.ctx     = c;
    send_word(rq);
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_reserved(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reserved_q  = v;
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [63:0] seen,
                               input logic [63:0] want);
    if (mismatch_count < REPORT_CAP)
      $display("%0t: %s mismatch: got %h, want %h", $time, what, seen, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    vec_result_t seen;
    vec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[136:0];
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected word", seen.handler, '0);
      end else begin
        want = expected_results.pop_front();
        if (seen.ok != want.ok)           flag_mismatch("ok", 64'(seen.ok),
                                                        64'(want.ok));
        if (seen.granted != want.granted) flag_mismatch("granted_vector",
                                                        64'(seen.granted),
                                                        64'(want.granted));
        if (seen.handler != want.handler) flag_mismatch("handler_out",
                                                        seen.handler, want.handler);
        if (seen.ctx != want.ctx)         flag_mismatch("context_out",
                                                        seen.ctx, want.ctx);
      end
    end
    // receiver backpressure in bursts
    if (stall_left != 0)
      stall_left--;
    else if (receiver_stalls_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 17);
    m_axis_tready <= rst_ni && (stall_left == 0);
  end

  // ends a hung run: no word moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes and every special case, reserved vector at its reset value.
  task automatic test_directed_cases();
    send_op(iva_pkg::OP_LOOKUP, 8'd32, '0, '0);       // free slot, ok 1, zeros
    send_op(iva_pkg::OP_LOOKUP, 8'd31, '1, '1);       // just below the table
    send_op(iva_pkg::OP_LOOKUP, 8'd0, '0, '0);
    send_op(iva_pkg::OP_FREE, 8'd31, '0, '0);         // invalid free
    send_op(iva_pkg::OP_ALLOC_SPEC, 8'd0, '1, '1);    // invalid specific
    send_op(iva_pkg::OP_ALLOC, 8'hFF, '1, '1);        // gets 32
    // zero handler: 33 stays free
    send_op(iva_pkg::OP_ALLOC, 8'h00, '0, 64'h5A5A_5A5A_5A5A_5A5A);
    send_op(iva_pkg::OP_LOOKUP, 8'd33, '0, '0);
    send_op(iva_pkg::OP_ALLOC, 8'd0, rand64(), rand64());  // 33 again
    send_op(iva_pkg::OP_LOOKUP, 8'd33, '0, '0);
    send_op(iva_pkg::OP_LOOKUP, 8'd32, '0, '0);
    send_op(iva_pkg::OP_ALLOC_SPEC, iva_pkg::FIXED_SKIP_VECTOR, '1, '1); // refused
    send_op(iva_pkg::OP_ALLOC_SPEC, iva_pkg::RESERVED_RESET, '1, '1);    // refused
    send_op(iva_pkg::OP_ALLOC_SPEC, 8'd255, rand64(), rand64());
    send_op(iva_pkg::OP_LOOKUP, 8'd255, '0, '0);      // top vector is valid
    send_op(iva_pkg::OP_ALLOC_SPEC, 8'd255, '1, '0);  // overwrite
    send_op(iva_pkg::OP_LOOKUP, 8'd255, '0, '0);
    send_op(iva_pkg::OP_ALLOC_SPEC, 8'd40, '0, rand64()); // zero handler stays free
    send_op(iva_pkg::OP_LOOKUP, 8'd40, '0, '0);
    send_op(iva_pkg::OP_FREE, 8'd41, '0, '0);         // already free
    send_op(iva_pkg::OP_FREE, 8'd32, '1, '1);
    send_op(iva_pkg::OP_LOOKUP, 8'd32, '0, '0);
    send_op(iva_pkg::OP_FREE, iva_pkg::FIXED_SKIP_VECTOR, '0, '0);  // valid slot
    send_op(iva_pkg::OP_LOOKUP, iva_pkg::FIXED_SKIP_VECTOR, '0, '0);
    send_op(iva_pkg::OP_ALLOC, 8'd0, rand64(), '0);   // lowest free is 32 again
  endtask

  // Fills the table with the reserved vector at its low extreme, hits the
  // full case, then moves the reserved vector to the top.
  task automatic test_full_table();
    wait_all_results();
    write_reserved(8'd32);
    repeat (iva_pkg::SLOT_COUNT)
      send_op(iva_pkg::OP_ALLOC, 8'($urandom), rand64() | 64'h1, rand64());
    send_op(iva_pkg::OP_ALLOC, 8'd0, '1, '1);         // full
    repeat (6) send_op(iva_pkg::OP_LOOKUP, 8'($urandom_range(32, 255)), '0, '0);
    send_op(iva_pkg::OP_ALLOC_SPEC, 8'd32, '1, '1);   // reserved: refused
    wait_all_results();
    write_reserved(8'd255);
    send_op(iva_pkg::OP_FREE, 8'd255, '0, '0);
    send_op(iva_pkg::OP_ALLOC, 8'd0, rand64(), rand64());  // 255 free but reserved
    send_op(iva_pkg::OP_ALLOC, 8'd0, rand64(), rand64());  // full again
    send_op(iva_pkg::OP_ALLOC_SPEC, 8'd255, '1, '1);  // refused
    send_op(iva_pkg::OP_ALLOC_SPEC, 8'd32, rand64(), rand64()); // overwrite
    send_op(iva_pkg::OP_LOOKUP, 8'd32, '0, '0);
  endtask

  // Mixed traffic; the op mix leans toward frees while the table is crowded
  // so that allocation keeps finding both free and full tables.
  task automatic test_random_traffic(input int n_words, input logic [7:0] reserved,
                                     input bit with_idling);
    vec_request_t rq;
    int           fill;
    int           pick;
    int           alloc_pct;
    int           free_pct;
    int           vsel;
    wait_all_results();
    write_reserved(reserved);
    sender_gaps_on     = with_idling;
    receiver_stalls_on = with_idling;
    repeat (n_words) begin
      fill      = $countones(slot_busy);
      alloc_pct = (fill > 170) ? 10 : 40;
      free_pct  = (fill > 170) ? 45 : 20;
      pick      = $urandom_range(0, 99);
      if (pick < alloc_pct)                      rq.opcode = iva_pkg::OP_ALLOC;
      else if (pick < alloc_pct + free_pct)      rq.opcode = iva_pkg::OP_FREE;
      else if (pick < alloc_pct + free_pct + 15) rq.opcode = iva_pkg::OP_ALLOC_SPEC;
      else                                       rq.opcode = iva_pkg::OP_LOOKUP;
      vsel = $urandom_range(0, 9);
      if (vsel == 0)
        rq.vector = 8'($urandom_range(0, iva_pkg::VECTOR_BASE - 1));
      else if (vsel == 1)
        rq.vector = ($urandom_range(0, 1) != 0) ? iva_pkg::FIXED_SKIP_VECTOR
                                                : reserved_q;
      else
        rq.vector = 8'($urandom_range(iva_pkg::VECTOR_BASE, 255));
      case ($urandom_range(0, 9))
        0:       rq.handler = '0;
        1:       rq.handler = '1;
        default: rq.handler = rand64();
      endcase
      rq.ctx = ($urandom_range(0, 9) == 0) ? '0 : rand64();
      send_word(rq);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_full_table();
    test_random_traffic(100, 8'($urandom_range(0, 255)), 1'b1);
    test_random_traffic(60, iva_pkg::FIXED_SKIP_VECTOR, 1'b0);  // no idling at all
    test_random_traffic(100, 8'd0, 1'b1);                // reserved outside table
    test_random_traffic(80, iva_pkg::RESERVED_RESET, 1'b0); // closing stretch, no idling
    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
